// ===== rtl/core/pqed_pkg.sv =====
// pqed_pkg: shared constants, codes, types and helper functions of the
// palette quantizer with error diffusion; used by every file in rtl/core but pqed_ram
`default_nettype none

package pqed_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int CACHE_ENTRIES_DEF = 32768;

   localparam int CH_W      = 8;
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 8;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int ERR_W     = 32;
   localparam int DIST_W    = 18;
   localparam int EPOCH_W   = 4;
   localparam int COLOR_W   = 3 * CH_W;
   localparam int ABS_SUM_W = 10;

   localparam logic [DIST_W-1:0] DIST_BOUND     = 18'd200000;
   localparam logic [CFG_W-1:0]  PAL_SIZE_RESET = 9'd256;
   localparam logic [CH_W-1:0]   CH_MAX         = 8'd255;

   localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BASE   = 2'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_ERR
   } ctl_state_type;

   typedef enum logic [1:0] {
      SR_IDLE,
      SR_RUN,
      SR_DONE
   } srch_state_type;

   typedef struct packed {
      logic            start;
      logic [CH_W-1:0] cr;
      logic [CH_W-1:0] cg;
      logic [CH_W-1:0] cb;
   } srch_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] best;
   } srch_rsp_type;

   // pixel plus half the carried error (floor), clamped to 0..255
   function automatic logic [CH_W-1:0] adjust_channel(input logic [CH_W-1:0] c,
                                                      input logic signed [CH_W:0] carry);
      logic signed [CH_W+1:0] s;
      logic [CH_W-1:0]        res;
      s = $signed({2'b00, c}) + $signed({carry[CH_W], carry[CH_W], carry[CH_W:1]});
      if (s[CH_W+1]) begin
         res = '0;
      end else if (s[CH_W]) begin
         res = CH_MAX;
      end else begin
         res = s[CH_W-1:0];
      end
      return res;
   endfunction

   // centre of the 8-wide cell holding c
   function automatic logic [CH_W-1:0] cell_centre(input logic [CH_W-1:0] c);
      return {c[CH_W-1:3], 3'b100};
   endfunction

   function automatic logic [CH_W-1:0] abs_diff(input logic signed [CH_W:0] d);
      logic signed [CH_W:0] m;
      m = d[CH_W] ? -d : d;
      return m[CH_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pqed_if.sv =====
// pqed_req_if / pqed_rsp_if: valid-ready channels of the quantizer
// depends on pqed_pkg for field widths
`default_nettype none

interface pqed_req_if;
   logic                         valid;
   logic                         ready;
   logic [pqed_pkg::MODE_W-1:0]  mode;
   logic [pqed_pkg::CH_W-1:0]    red;
   logic [pqed_pkg::CH_W-1:0]    green;
   logic [pqed_pkg::CH_W-1:0]    blue;
   logic [pqed_pkg::IDX_W-1:0]   palette_slot;
   logic                         row_start;

   modport source (output valid, mode, red, green, blue, palette_slot, row_start,
                   input ready);
   modport sink (input valid, mode, red, green, blue, palette_slot, row_start,
                 output ready);
endinterface

interface pqed_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pqed_pkg::IDX_W-1:0]  pen_index;
   logic [pqed_pkg::ERR_W-1:0]  error_sum;

   modport source (output valid, pen_index, error_sum, input ready);
   modport sink (input valid, pen_index, error_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pqed_ram.sv =====
// pqed_ram: single write port, single read port memory with registered read
// used for the palette store and the color cache; no package dependency
`default_nettype none

module pqed_ram #(
   parameter int DEPTH  = 2,
   parameter int DATA_W = 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pqed_search.sv =====
// pqed_search: nearest palette entry search, one shared squarer stepping
// over channels and entries; depends on pqed_pkg, reads the palette ram
`default_nettype none

module pqed_search #(
   parameter int PALETTE_DEPTH = pqed_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pqed_pkg::srch_req_type             req,
   input  wire logic [$clog2(PALETTE_DEPTH):0]     limit,
   output      pqed_pkg::srch_rsp_type             rsp,
   output      logic                               pal_rd_en,
   output      logic [$clog2(PALETTE_DEPTH)-1:0]   pal_rd_addr,
   input  wire logic [pqed_pkg::COLOR_W-1:0]       pal_rdata
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int CNT_W  = PAL_AW + 1;
   localparam int CH_W   = pqed_pkg::CH_W;
   localparam int DIST_W = pqed_pkg::DIST_W;

   pqed_pkg::srch_state_type   state_ff, state_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [pqed_pkg::IDX_W-1:0] best_ff, best_in;
   logic [DIST_W-1:0]          min_ff, min_in;
   logic [DIST_W-1:0]          acc_ff, acc_in;
   logic [CH_W-1:0]            cr_ff, cr_in;
   logic [CH_W-1:0]            cg_ff, cg_in;
   logic [CH_W-1:0]            cb_ff, cb_in;

   logic [CH_W-1:0]            ent_ch;
   logic [CH_W-1:0]            cen_ch;
   logic [CH_W-1:0]            mag;
   logic [2*CH_W-1:0]          sq;
   logic [DIST_W-1:0]          dist_sum;
   logic [CNT_W-1:0]           idx_next;

   // shared squared-difference unit, one channel per cycle
   always_comb begin
      case (phase_ff)
         2'd0: begin
            ent_ch = pal_rdata[3*CH_W-1:2*CH_W];
            cen_ch = cr_ff;
         end
         2'd1: begin
            ent_ch = pal_rdata[2*CH_W-1:CH_W];
            cen_ch = cg_ff;
         end
         default: begin
            ent_ch = pal_rdata[CH_W-1:0];
            cen_ch = cb_ff;
         end
      endcase
      mag      = pqed_pkg::abs_diff($signed({1'b0, ent_ch}) - $signed({1'b0, cen_ch}));
      sq       = mag * mag;
      dist_sum = acc_ff + DIST_W'(sq);
      idx_next = idx_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pqed_pkg::SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      idx_ff   <= idx_in;
      limit_ff <= limit_in;
      best_ff  <= best_in;
      min_ff   <= min_in;
      acc_ff   <= acc_in;
      cr_ff    <= cr_in;
      cg_ff    <= cg_in;
      cb_ff    <= cb_in;
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      limit_in    = limit_ff;
      best_in     = best_ff;
      min_in      = min_ff;
      acc_in      = acc_ff;
      cr_in       = cr_ff;
      cg_in       = cg_ff;
      cb_in       = cb_ff;
      pal_rd_en   = 1'b0;
      pal_rd_addr = '0;
      rsp.done    = 1'b0;
      rsp.best    = best_ff;

      case (state_ff)
         pqed_pkg::SR_IDLE: begin
            if (req.start) begin
               cr_in    = req.cr;
               cg_in    = req.cg;
               cb_in    = req.cb;
               limit_in = limit;
               idx_in   = '0;
               best_in  = '0;
               min_in   = pqed_pkg::DIST_BOUND;
               phase_in = 2'd0;
               if (limit == '0) begin
                  state_in = pqed_pkg::SR_DONE;
               end else begin
                  pal_rd_en = 1'b1;
                  state_in  = pqed_pkg::SR_RUN;
               end
            end
         end
         pqed_pkg::SR_RUN: begin
            case (phase_ff)
               2'd0: begin
                  acc_in   = DIST_W'(sq);
                  phase_in = 2'd1;
               end
               2'd1: begin
                  acc_in   = dist_sum;
                  phase_in = 2'd2;
               end
               default: begin
                  if (dist_sum < min_ff) begin
                     min_in  = dist_sum;
                     best_in = pqed_pkg::IDX_W'(idx_ff);
                  end
                  idx_in   = idx_next;
                  phase_in = 2'd0;
                  if (idx_next == limit_ff) begin
                     state_in = pqed_pkg::SR_DONE;
                  end else begin
                     pal_rd_en   = 1'b1;
                     pal_rd_addr = idx_next[PAL_AW-1:0];
                  end
               end
            endcase
         end
         pqed_pkg::SR_DONE: begin
            rsp.done = 1'b1;
            state_in = pqed_pkg::SR_IDLE;
         end
         default: begin
            state_in = pqed_pkg::SR_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/palette_quantizer_error_diffusion.sv =====
// palette_quantizer_error_diffusion: top level, control sequencer, cache and
// palette memories, error carry; depends on pqed_pkg, pqed_if, pqed_ram, pqed_search
// cache hit: ST_CHECK then ST_ERR, which waits for a free result register; then input is ready again
// cache miss: ST_SEARCH steps a shared squarer over each channel of each palette entry
// load and frame start leave the block idle; every 15th frame start sweeps the cache
// reset: synchronous; a cache clearing sweep follows, no transactions taken
`default_nettype none

module palette_quantizer_error_diffusion #(
   parameter int PALETTE_DEPTH = pqed_pkg::PALETTE_DEPTH_DEF,
   parameter int CACHE_ENTRIES = pqed_pkg::CACHE_ENTRIES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pqed_req_if.sink                              req_bus,
   pqed_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [pqed_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pqed_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
   localparam int CNT_W    = PAL_AW + 1;
   localparam int CACHE_AW = $clog2(CACHE_ENTRIES);
   localparam int CH_W     = pqed_pkg::CH_W;
   localparam int IDX_W    = pqed_pkg::IDX_W;
   localparam int EPOCH_W  = pqed_pkg::EPOCH_W;
   localparam int ENTRY_W  = EPOCH_W + IDX_W;
   localparam int ERR_W    = pqed_pkg::ERR_W;
   localparam int SUM_W    = pqed_pkg::ABS_SUM_W;

   pqed_pkg::ctl_state_type      state_ff, state_in;
   logic [CACHE_AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0]           epoch_ff, epoch_in;
   logic [CH_W-1:0]              r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [CACHE_AW-1:0]          key_ff, key_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic signed [CH_W:0]         carry_r_ff, carry_r_in;
   logic signed [CH_W:0]         carry_g_ff, carry_g_in;
   logic signed [CH_W:0]         carry_b_ff, carry_b_in;
   logic [ERR_W-1:0]             frame_err_ff, frame_err_in;
   logic [pqed_pkg::CFG_W-1:0]   palette_size_ff, palette_size_in;
   logic [IDX_W-1:0]             index_base_ff, index_base_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]             rsp_pen_ff, rsp_pen_in;
   logic [ERR_W-1:0]             rsp_err_ff, rsp_err_in;

   logic                         req_fire;
   logic signed [CH_W:0]         use_r, use_g, use_b;
   logic [CH_W-1:0]              adj_r, adj_g, adj_b;
   logic [CACHE_AW-1:0]          adj_key;
   logic [CNT_W-1:0]             limit;

   logic                         pal_wr_en;
   logic                         pal_rd_en;
   logic [PAL_AW-1:0]            pal_rd_addr;
   logic [pqed_pkg::COLOR_W-1:0] pal_rdata;
   logic                         top_rd_en;
   logic [PAL_AW-1:0]            top_rd_addr;
   logic                         srch_rd_en;
   logic [PAL_AW-1:0]            srch_rd_addr;

   logic                         cache_wr_en;
   logic [CACHE_AW-1:0]          cache_wr_addr;
   logic [ENTRY_W-1:0]           cache_wr_data;
   logic                         cache_rd_en;
   logic [ENTRY_W-1:0]           cache_rdata;
   logic                         cache_hit;

   pqed_pkg::srch_req_type       srch_req;
   pqed_pkg::srch_rsp_type       srch_rsp;

   logic signed [CH_W:0]         err_r, err_g, err_b;
   logic [SUM_W-1:0]             abs_sum;
   logic [ERR_W:0]               err_total;
   logic                         out_free;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == pqed_pkg::ST_IDLE);

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pen_index = rsp_pen_ff;
   assign rsp_bus.error_sum = rsp_err_ff;

   // adjusted pixel and cache key for the incoming transaction
   always_comb begin
      use_r   = req_bus.row_start ? '0 : carry_r_ff;
      use_g   = req_bus.row_start ? '0 : carry_g_ff;
      use_b   = req_bus.row_start ? '0 : carry_b_ff;
      adj_r   = pqed_pkg::adjust_channel(req_bus.red, use_r);
      adj_g   = pqed_pkg::adjust_channel(req_bus.green, use_g);
      adj_b   = pqed_pkg::adjust_channel(req_bus.blue, use_b);
      adj_key = CACHE_AW'({adj_r[CH_W-1:3], adj_g[CH_W-1:3], adj_b[CH_W-1:3]});
      if ({1'b0, palette_size_ff} > (pqed_pkg::CFG_W + 1)'(PALETTE_DEPTH)) begin
         limit = CNT_W'(PALETTE_DEPTH);
      end else begin
         limit = CNT_W'(palette_size_ff);
      end
   end

   // residual error of the chosen entry
   always_comb begin
      err_r     = $signed({1'b0, r_ff}) - $signed({1'b0, pal_rdata[3*CH_W-1:2*CH_W]});
      err_g     = $signed({1'b0, g_ff}) - $signed({1'b0, pal_rdata[2*CH_W-1:CH_W]});
      err_b     = $signed({1'b0, b_ff}) - $signed({1'b0, pal_rdata[CH_W-1:0]});
      abs_sum   = SUM_W'(pqed_pkg::abs_diff(err_r)) + SUM_W'(pqed_pkg::abs_diff(err_g))
                + SUM_W'(pqed_pkg::abs_diff(err_b));
      err_total = {1'b0, frame_err_ff} + (ERR_W + 1)'(abs_sum);
      out_free  = !rsp_valid_ff || rsp_bus.ready;
      cache_hit = (cache_rdata[ENTRY_W-1:IDX_W] == epoch_ff);
   end

   assign pal_wr_en   = req_fire && (req_bus.mode == pqed_pkg::MODE_LOAD)
                     && ((IDX_W + 1)'(req_bus.palette_slot) < (IDX_W + 1)'(PALETTE_DEPTH));
   assign pal_rd_en   = top_rd_en || srch_rd_en;
   assign pal_rd_addr = top_rd_en ? top_rd_addr : srch_rd_addr;
   assign cache_rd_en = req_fire && (req_bus.mode == pqed_pkg::MODE_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pqed_pkg::ST_CLEAR;
         clr_addr_ff     <= '0;
         epoch_ff        <= EPOCH_W'(1);
         carry_r_ff      <= '0;
         carry_g_ff      <= '0;
         carry_b_ff      <= '0;
         frame_err_ff    <= '0;
         palette_size_ff <= pqed_pkg::PAL_SIZE_RESET;
         index_base_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         epoch_ff        <= epoch_in;
         carry_r_ff      <= carry_r_in;
         carry_g_ff      <= carry_g_in;
         carry_b_ff      <= carry_b_in;
         frame_err_ff    <= frame_err_in;
         palette_size_ff <= palette_size_in;
         index_base_ff   <= index_base_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      r_ff       <= r_in;
      g_ff       <= g_in;
      b_ff       <= b_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      rsp_pen_ff <= rsp_pen_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_comb begin
      palette_size_in = palette_size_ff;
      index_base_in   = index_base_ff;
      if (csr_we) begin
         case (csr_index)
            pqed_pkg::CSR_PALETTE_SIZE: palette_size_in = csr_wdata;
            pqed_pkg::CSR_INDEX_BASE:   index_base_in   = csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      epoch_in      = epoch_ff;
      r_in          = r_ff;
      g_in          = g_ff;
      b_in          = b_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      carry_r_in    = carry_r_ff;
      carry_g_in    = carry_g_ff;
      carry_b_in    = carry_b_ff;
      frame_err_in  = frame_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_pen_in    = rsp_pen_ff;
      rsp_err_in    = rsp_err_ff;
      top_rd_en     = 1'b0;
      top_rd_addr   = '0;
      cache_wr_en   = 1'b0;
      cache_wr_addr = clr_addr_ff;
      cache_wr_data = '0;
      srch_req.start = 1'b0;
      srch_req.cr    = pqed_pkg::cell_centre(r_ff);
      srch_req.cg    = pqed_pkg::cell_centre(g_ff);
      srch_req.cb    = pqed_pkg::cell_centre(b_ff);

      case (state_ff)
         pqed_pkg::ST_CLEAR: begin
            cache_wr_en = 1'b1;
            clr_addr_in = clr_addr_ff + CACHE_AW'(1);
            if (clr_addr_ff == {CACHE_AW{1'b1}}) begin
               epoch_in = EPOCH_W'(1);
               state_in = pqed_pkg::ST_IDLE;
            end
         end
         pqed_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.mode)
                  pqed_pkg::MODE_PIXEL: begin
                     r_in     = adj_r;
                     g_in     = adj_g;
                     b_in     = adj_b;
                     key_in   = adj_key;
                     state_in = pqed_pkg::ST_CHECK;
                  end
                  pqed_pkg::MODE_FRAME: begin
                     frame_err_in = '0;
                     if (epoch_ff == {EPOCH_W{1'b1}}) begin
                        clr_addr_in = '0;
                        state_in    = pqed_pkg::ST_CLEAR;
                     end else begin
                        epoch_in = epoch_ff + EPOCH_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         pqed_pkg::ST_CHECK: begin
            if (cache_hit) begin
               idx_in      = cache_rdata[IDX_W-1:0];
               top_rd_en   = 1'b1;
               top_rd_addr = cache_rdata[PAL_AW-1:0];
               state_in    = pqed_pkg::ST_ERR;
            end else begin
               srch_req.start = 1'b1;
               state_in       = pqed_pkg::ST_SEARCH;
            end
         end
         pqed_pkg::ST_SEARCH: begin
            if (srch_rsp.done) begin
               idx_in        = srch_rsp.best;
               top_rd_en     = 1'b1;
               top_rd_addr   = srch_rsp.best[PAL_AW-1:0];
               cache_wr_en   = 1'b1;
               cache_wr_addr = key_ff;
               cache_wr_data = {epoch_ff, srch_rsp.best};
               state_in      = pqed_pkg::ST_ERR;
            end
         end
         pqed_pkg::ST_ERR: begin
            if (out_free) begin
               carry_r_in   = err_r;
               carry_g_in   = err_g;
               carry_b_in   = err_b;
               frame_err_in = err_total[ERR_W] ? {ERR_W{1'b1}} : err_total[ERR_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_pen_in   = idx_ff + index_base_ff;
               rsp_err_in   = frame_err_in;
               state_in     = pqed_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pqed_pkg::ST_IDLE;
         end
      endcase
   end

   pqed_ram #(
      .DEPTH  (PALETTE_DEPTH),
      .DATA_W (pqed_pkg::COLOR_W)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_bus.palette_slot[PAL_AW-1:0]),
      .wr_data ({req_bus.red, req_bus.green, req_bus.blue}),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rdata)
   );

   pqed_ram #(
      .DEPTH  (CACHE_ENTRIES),
      .DATA_W (ENTRY_W)
   ) u_cache_ram (
      .clock   (clock),
      .wr_en   (cache_wr_en),
      .wr_addr (cache_wr_addr),
      .wr_data (cache_wr_data),
      .rd_en   (cache_rd_en),
      .rd_addr (adj_key),
      .rd_data (cache_rdata)
   );

   pqed_search #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .req         (srch_req),
      .limit       (limit),
      .rsp         (srch_rsp),
      .pal_rd_en   (srch_rd_en),
      .pal_rd_addr (srch_rd_addr),
      .pal_rdata   (pal_rdata)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pqed_checker.sv =====
// pqed_checker: port-level assertions for the quantizer top level, and its bind
// depends on pqed_pkg and palette_quantizer_error_diffusion
`default_nettype none

module pqed_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [pqed_pkg::MODE_W-1:0]      req_mode,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [pqed_pkg::IDX_W-1:0]       rsp_pen_index,
   input wire logic [pqed_pkg::ERR_W-1:0]       rsp_error_sum
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pen_index)
                                  && $stable(rsp_error_sum))
      else $error("result changed while stalled");

   // cache sweep after reset blocks input
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input ready right after reset");

   // an accepted pixel drops input ready in the next cycle
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == pqed_pkg::MODE_PIXEL) |=> !req_ready)
      else $error("ready right after pixel transaction");

   // non-pixel transactions produce no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode != pqed_pkg::MODE_PIXEL) && !rsp_valid
      |=> !rsp_valid)
      else $error("result after non-pixel transaction");

endmodule

bind palette_quantizer_error_diffusion pqed_checker u_pqed_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_mode      (req_bus.mode),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pen_index (rsp_bus.pen_index),
   .rsp_error_sum (rsp_bus.error_sum)
);

`default_nettype wire
